/* rtl/cpa_pkg.sv */
// cpa_pkg: shared types and constants for the chunk pool allocator
// no dependencies
package cpa_pkg;

   localparam int MAX_ENTRIES    = 256;
   localparam int KEY_BITS       = $clog2(MAX_ENTRIES);
   localparam int CNT_BITS       = KEY_BITS + 1;
   localparam int HEAP_ADDR_BITS = 16;
   localparam int BYTES_BITS     = 17;
   localparam int CLAMP_BITS     = 9;
   localparam int ENTRY_BITS     = 1 + HEAP_ADDR_BITS + BYTES_BITS;
   localparam int ADDR_BITS      = 4;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_ZERO   = 2'd1,
      ST_FULL   = 2'd2,
      ST_BADKEY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_CLUSTER = 2'd0,
      REG_SLACK   = 2'd1,
      REG_MAXNEW  = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic                      free;
      logic [HEAP_ADDR_BITS-1:0] address;
      logic [BYTES_BITS-1:0]     bytes;
   } entry_type;

   typedef struct packed {
      logic                wr_en;
      logic [KEY_BITS-1:0] wr_addr;
      entry_type           wr_data;
      logic [KEY_BITS-1:0] rd_addr;
   } mem_req_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_RELEASE_RD, S_RELEASE_WR,
      S_DIV, S_MUL, S_CHECK, S_CARVE, S_GRANT, S_RESP
   } state_type;

endpackage

/* rtl/cpa_table.sv */
// cpa_table: chunk table memory, one write port, one registered read port
// depends on cpa_pkg
module cpa_table (
   input  logic                clock,
   input  cpa_pkg::mem_req_type mem_req,
   output cpa_pkg::entry_type  rd_data
);
   import cpa_pkg::*;

   entry_type mem [MAX_ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= mem[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/cpa_divider.sv */
// cpa_divider: restoring divider, one quotient bit per cycle
// depends on cpa_pkg
module cpa_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [cpa_pkg::BYTES_BITS-1:0] dividend,
   input  logic [cpa_pkg::BYTES_BITS-1:0] divisor,
   output logic                           done,
   output logic [cpa_pkg::BYTES_BITS-1:0] quotient
);
   import cpa_pkg::*;

   localparam int CW = $clog2(BYTES_BITS + 1);

   logic [BYTES_BITS-1:0] quo_ff, quo_in;
   logic [BYTES_BITS:0]   rem_ff, rem_in;
   logic [BYTES_BITS-1:0] div_ff, div_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [BYTES_BITS:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[BYTES_BITS-1:0], quo_ff[BYTES_BITS-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CW'(BYTES_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
            quo_in = {quo_ff[BYTES_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[BYTES_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

/* rtl/cpa_ctrl.sv */
// cpa_ctrl: sequencer for scan, release and cluster carving
// depends on cpa_pkg and cpa_divider
module cpa_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                action,
   input  logic [cpa_pkg::BYTES_BITS-1:0]      request_bytes,
   input  logic [cpa_pkg::KEY_BITS-1:0]        release_key,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cpa_pkg::status_type                 status,
   output logic [cpa_pkg::KEY_BITS-1:0]        chunk_key,
   output logic [cpa_pkg::HEAP_ADDR_BITS-1:0]  chunk_address,
   input  logic [cpa_pkg::BYTES_BITS-1:0]      cluster_bytes,
   input  logic [cpa_pkg::BYTES_BITS-1:0]      size_slack,
   input  logic [cpa_pkg::CLAMP_BITS-1:0]      chunk_clamp,
   output cpa_pkg::mem_req_type                mem_req,
   input  cpa_pkg::entry_type                  rd_data
);
   import cpa_pkg::*;

   localparam int HB = HEAP_ADDR_BITS + 1;
   localparam int SPAN_BITS = BYTES_BITS + CLAMP_BITS;

   state_type state_ff, state_in;
   logic [BYTES_BITS-1:0]     req_ff, req_in;
   logic [KEY_BITS-1:0]       key_ff, key_in;
   logic [CNT_BITS-1:0]       idx_ff, idx_in;
   logic [CNT_BITS-1:0]       count_ff, count_in;
   logic [HB-1:0]             top_ff, top_in;
   logic [BYTES_BITS-1:0]     rnd_ff, rnd_in;
   logic [CLAMP_BITS-1:0]     num_ff, num_in;
   logic [SPAN_BITS-1:0]      span_ff, span_in;
   logic [HEAP_ADDR_BITS-1:0] addr_ff, addr_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                st_ff, st_in;
   logic [KEY_BITS-1:0]       okey_ff, okey_in;
   logic [HEAP_ADDR_BITS-1:0] oaddr_ff, oaddr_in;

   logic                  div_start, div_done;
   logic [BYTES_BITS-1:0] quotient;
   logic [BYTES_BITS:0]   rnd_wide;
   logic [BYTES_BITS:0]   diff;
   logic [CLAMP_BITS-1:0] clamp;
   logic [SPAN_BITS:0]    heap_end;
   logic                  req_take;

   cpa_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cluster_bytes),
      .divisor  (rnd_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      rnd_in       = rnd_ff;
      num_in       = num_ff;
      span_in      = span_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff;
      st_in        = st_ff;
      okey_in      = okey_ff;
      oaddr_in     = oaddr_ff;
      div_start    = 1'b0;
      mem_req      = '0;
      mem_req.rd_addr = idx_ff[KEY_BITS-1:0];
      rnd_wide     = ({1'b0, req_ff} + (BYTES_BITS+1)'(15)) & ~(BYTES_BITS+1)'('hF);
      diff         = {1'b0, rd_data.bytes} - {1'b0, req_ff};
      clamp        = (chunk_clamp == '0) ? CLAMP_BITS'(1) : chunk_clamp;
      heap_end     = (SPAN_BITS+1)'(top_ff) + (SPAN_BITS+1)'(span_ff);
      req_ready    = (state_ff == S_IDLE) && !rsp_valid_ff;
      req_take     = req_valid && req_ready;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               req_in = request_bytes;
               key_in = release_key;
               idx_in = '0;
               if (action) begin
                  if (CNT_BITS'(release_key) >= count_ff) begin
                     st_in = ST_BADKEY;
                     state_in = S_RESP;
                  end else begin
                     state_in = S_RELEASE_RD;
                  end
               end else if (request_bytes == '0) begin
                  st_in = ST_ZERO;
                  state_in = S_RESP;
               end else if (request_bytes > BYTES_BITS'(65536)) begin
                  st_in = ST_FULL;
                  state_in = S_RESP;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            if (idx_ff >= count_ff) begin
               rnd_in = rnd_wide[BYTES_BITS-1:0];
               state_in = S_DIV;
            end else begin
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (rd_data.free && (req_ff <= rd_data.bytes) &&
                (diff < {1'b0, size_slack})) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = idx_ff[KEY_BITS-1:0];
               mem_req.wr_data = rd_data;
               mem_req.wr_data.free = 1'b0;
               st_in    = ST_OK;
               okey_in  = idx_ff[KEY_BITS-1:0];
               oaddr_in = rd_data.address;
               state_in = S_RESP;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_RELEASE_RD: begin
            mem_req.rd_addr = key_ff;
            state_in = S_RELEASE_WR;
         end
         S_RELEASE_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = key_ff;
            mem_req.wr_data = rd_data;
            mem_req.wr_data.free = 1'b1;
            st_in    = ST_OK;
            state_in = S_RESP;
         end
         S_DIV: begin
            // first cycle kicks the divider, idx all ones marks it running
            if (idx_ff != '1) begin
               div_start = 1'b1;
               idx_in    = '1;
            end else if (div_done) begin
               if (quotient == '0) begin
                  num_in = CLAMP_BITS'(1);
               end else if (quotient > BYTES_BITS'(clamp)) begin
                  num_in = clamp;
               end else begin
                  num_in = quotient[CLAMP_BITS-1:0];
               end
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            span_in  = SPAN_BITS'(num_ff) * SPAN_BITS'(rnd_ff);
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if ((CNT_BITS+1)'(count_ff) + (CNT_BITS+1)'(num_ff) >
                (CNT_BITS+1)'(MAX_ENTRIES) ||
                heap_end > (SPAN_BITS+1)'(1 << HEAP_ADDR_BITS)) begin
               st_in    = ST_FULL;
               state_in = S_RESP;
            end else begin
               idx_in   = count_ff;
               addr_in  = top_ff[HEAP_ADDR_BITS-1:0];
               okey_in  = count_ff[KEY_BITS-1:0];
               oaddr_in = top_ff[HEAP_ADDR_BITS-1:0];
               st_in    = ST_OK;
               state_in = S_CARVE;
            end
         end
         S_CARVE: begin
            // first chunk goes out taken, the rest free
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_ff[KEY_BITS-1:0];
            mem_req.wr_data.free    = (idx_ff != count_ff);
            mem_req.wr_data.address = addr_ff;
            mem_req.wr_data.bytes   = rnd_ff;
            addr_in = addr_ff + rnd_ff[HEAP_ADDR_BITS-1:0];
            idx_in  = idx_ff + 1'b1;
            if (idx_ff + 1'b1 == count_ff + CNT_BITS'(num_ff)) begin
               state_in = S_GRANT;
            end
         end
         S_GRANT: begin
            count_in = count_ff + CNT_BITS'(num_ff);
            top_in   = HB'(heap_end);
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         top_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
      end
      req_ff   <= req_in;
      key_ff   <= key_in;
      idx_ff   <= idx_in;
      rnd_ff   <= rnd_in;
      num_ff   <= num_in;
      span_ff  <= span_in;
      addr_ff  <= addr_in;
      st_ff    <= st_in;
      // key and address start at zero for each new transaction
      okey_ff  <= req_take ? '0 : okey_in;
      oaddr_ff <= req_take ? '0 : oaddr_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign status        = st_ff;
   assign chunk_key     = okey_ff;
   assign chunk_address = oaddr_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_ENTRIES))
      else $error("entry count beyond table");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == S_IDLE))
      else $error("ready outside idle");
   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> ($past(state_ff) == S_GRANT))
      else $error("entry count changed outside grant");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && st_ff != ST_OK) |-> (okey_ff == '0 && oaddr_ff == '0))
      else $error("error result carries key or address");
endmodule

/* rtl/chunk_pool_allocator.sv */
// chunk_pool_allocator: top level, config registers, table memory and sequencer
// depends on cpa_pkg, cpa_table, cpa_ctrl
// sequence: release reads the entry, writes it back free, then responds;
//   allocate reads and checks each scanned entry in turn, then on a miss runs the 17-step
//   divider path, a multiply and a bounds check, and writes each carved chunk in turn
// throughput: one transaction at a time; the worst case is a full 256-entry scan through the single table read port
// reset: synchronous; entry count and heap top clear, registers take defaults;
//   the table needs no clearing pass, only entries below the count are read
module chunk_pool_allocator (
   input  logic        clock,
   input  logic        reset,
   // tdata: action[0], request_bytes[17:1], release_key[25:18], zero fill to 32
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // tdata: status[1:0], chunk_key[9:2], chunk_address[25:10], zero fill to 32
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [cpa_pkg::ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import cpa_pkg::*;

   logic [BYTES_BITS-1:0] cluster_ff, slack_ff;
   logic [CLAMP_BITS-1:0] maxnew_ff;
   logic                  cfg_wr;
   logic [1:0]            reg_sel;
   mem_req_type           mem_req;
   entry_type             rd_data;
   status_type            status;
   logic [KEY_BITS-1:0]   chunk_key;
   logic [HEAP_ADDR_BITS-1:0] chunk_address;

   assign csr_pready = 1'b1;
   assign cfg_wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel = csr_paddr[3:2];

   // register writes; addresses beyond the list are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_ff <= BYTES_BITS'(1024);
         slack_ff   <= BYTES_BITS'(16);
         maxnew_ff  <= CLAMP_BITS'(16);
      end else if (cfg_wr && csr_paddr[1:0] == 2'b00) begin
         case (reg_sel)
            REG_CLUSTER: cluster_ff <= csr_pwdata[BYTES_BITS-1:0];
            REG_SLACK:   slack_ff   <= csr_pwdata[BYTES_BITS-1:0];
            REG_MAXNEW:  maxnew_ff  <= csr_pwdata[CLAMP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (reg_sel)
         REG_CLUSTER: csr_prdata = 32'(cluster_ff);
         REG_SLACK:   csr_prdata = 32'(slack_ff);
         REG_MAXNEW:  csr_prdata = 32'(maxnew_ff);
         default:     csr_prdata = '0;
      endcase
   end

   cpa_table u_table (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   cpa_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .action         (req_tdata[0]),
      .request_bytes  (req_tdata[17:1]),
      .release_key    (req_tdata[25:18]),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .status         (status),
      .chunk_key      (chunk_key),
      .chunk_address  (chunk_address),
      .cluster_bytes  (cluster_ff),
      .size_slack     (slack_ff),
      .chunk_clamp    (maxnew_ff),
      .mem_req        (mem_req),
      .rd_data        (rd_data)
   );

   assign rsp_tdata = {6'd0, chunk_address, chunk_key, status};
endmodule

/* verif/tb_top.sv */
// tb_top: self-checking testbench for chunk_pool_allocator
// depends on cpa_pkg and the chunk_pool_allocator rtl; drives request and apb ports,
// predicts each response from its own model of the chunk table and heap
module tb_top;
   import cpa_pkg::*;

   // packed with action in the lowest bit, as on req_tdata
   typedef struct packed {
      logic [7:0]  key;
      logic [16:0] req_bytes;
      logic        action;
   } request_t;

   // packed with status in the lowest bits, as on rsp_tdata
   typedef struct packed {
      logic [15:0] address;
      logic [7:0]  key;
      status_type  status;
   } grant_t;

   localparam logic ACT_ALLOC   = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;
   localparam int   STALL_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [ADDR_BITS-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   chunk_pool_allocator u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // predictor state: a mirror of the chunk table, heap pointer and registers
   logic        pool_free  [MAX_ENTRIES];
   logic [15:0] pool_addr  [MAX_ENTRIES];
   logic [16:0] pool_bytes [MAX_ENTRIES];
   int unsigned pool_count = 0;
   longint unsigned heap_top = 0;
   int unsigned cluster_bytes = 1024;
   int unsigned size_slack = 16;
   int unsigned max_new = 16;

   request_t pending_requests[$];
   grant_t   expected_grants[$];
   int       errors = 0;
   int       idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // predict the response to one request and update the mirror
   function automatic grant_t predict_grant(request_t r);
      grant_t g;
      int unsigned rounded, num;
      g = '{status: ST_OK, key: 8'd0, address: 16'd0};
      if (r.action == ACT_RELEASE) begin
         if (r.key >= pool_count) g.status = ST_BADKEY;
         else pool_free[r.key] = 1'b1;
         return g;
      end
      if (r.req_bytes == 0) begin
         g.status = ST_ZERO;
         return g;
      end
      if (r.req_bytes > 17'd65536) begin
         g.status = ST_FULL;
         return g;
      end
      // first fit over existing chunks within the slack
      for (int i = 0; i < pool_count; i++) begin
         if (pool_free[i] && r.req_bytes <= pool_bytes[i] &&
             pool_bytes[i] - r.req_bytes < size_slack) begin
            pool_free[i] = 1'b0;
            g.key = i[7:0];
            g.address = pool_addr[i];
            return g;
         end
      end
      // carve a new cluster from the heap
      rounded = (int'(r.req_bytes) + 15) & ~32'hF;
      num = cluster_bytes / rounded;
      if (num < 1) num = 1;
      else if (num > max_new) num = max_new;
      if (num < 1) num = 1;
      if (pool_count + num > MAX_ENTRIES ||
          heap_top + longint'(num) * rounded > 64'd65536) begin
         g.status = ST_FULL;
         return g;
      end
      for (int i = 0; i < num; i++) begin
         pool_free[pool_count + i]  = 1'b1;
         pool_addr[pool_count + i]  = 16'(heap_top + i * rounded);
         pool_bytes[pool_count + i] = 17'(rounded);
      end
      g.key = pool_count[7:0];
      g.address = 16'(heap_top);
      pool_free[pool_count] = 1'b0;
      pool_count += num;
      heap_top += longint'(num) * rounded;
      return g;
   endfunction

   // driver: sends queued requests with a random gap between transactions
   int send_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap   <= 0;
      end else if (req_tvalid && !req_tready) begin
         // hold until accepted
      end else begin
         if (req_tvalid) begin
            expected_grants.push_back(predict_grant(request_t'(req_tdata[25:0])));
         end
         if (send_gap > 0 || pending_requests.size() == 0) begin
            req_tvalid <= 1'b0;
            if (send_gap > 0) send_gap <= send_gap - 1;
         end else begin
            req_tdata  <= {6'd0, pending_requests.pop_front()};
            req_tvalid <= 1'b1;
            send_gap   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
         end
      end
   end

   // monitor: random stalls on the response side, compares each transaction
   int stall;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         stall       <= 0;
         idle_cycles <= 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            grant_t got;
            grant_t want;
            got = grant_t'(rsp_tdata[25:0]);
            if (expected_grants.size() == 0) begin
               $display("%0t unexpected response %h", $realtime, rsp_tdata);
               errors++;
            end else begin
               want = expected_grants.pop_front();
               if (got.status !== want.status || got.key !== want.key ||
                   got.address !== want.address) begin
                  $display("%0t expected status %0d key %0d addr %h, got %0d %0d %h",
                     $realtime, want.status, want.key, want.address,
                     got.status, got.key, got.address);
                  errors++;
               end
            end
            stall <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
            rsp_tready <= 1'b0;
         end else if (stall > 0) begin
            stall <= stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles > STALL_LIMIT) begin
         $display("chunk_pool_allocator: mismatch");
         $finish;
      end
   end

   // checked at the falling edge so that driver and monitor updates have settled
   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_tvalid || expected_grants.size() != 0)
         @(negedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, int unsigned value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_BITS'(4 * idx);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_CLUSTER: cluster_bytes = value & 32'h1FFFF;
         REG_SLACK:   size_slack    = value & 32'h1FFFF;
         default:     max_new       = value & 32'h1FF;
      endcase
   endtask

   function automatic void queue_alloc(int unsigned nbytes);
      pending_requests.push_back('{action: ACT_ALLOC, req_bytes: 17'(nbytes),
                                   key: 8'($urandom)});
   endfunction

   function automatic void queue_release(int unsigned k);
      pending_requests.push_back('{action: ACT_RELEASE, req_bytes: 17'($urandom),
                                   key: 8'(k)});
   endfunction

   // random phase: mostly small allocations and valid releases
   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         int unsigned pick = $urandom_range(0, 99);
         if (pick < 50)
            queue_alloc(pick < 5 ? $urandom_range(0, 131071) :
                        pick < 10 ? $urandom_range(1, 65536) : $urandom_range(1, 200));
         else if (pick < 90)
            queue_release(pool_count > 0 ? $urandom_range(0, pool_count + 2) : $urandom);
         else
            queue_release($urandom_range(0, 255));
      end
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero size, oversize, extremes, bad key, double release
      queue_alloc(0);
      queue_alloc(131071);
      queue_alloc(65537);
      queue_alloc(1);
      queue_alloc(16);
      queue_alloc(17);
      queue_release(0);
      queue_release(0);
      queue_alloc(10);
      queue_release(255);
      queue_release(200);
      queue_alloc(65536);
      queue_alloc(60000);
      queue_alloc(100);
      wait_drained();

      // reset defaults first, then small clusters and tight slack, then large, all-ones and mid values
      random_phase(300);
      csr_write(REG_CLUSTER, 16);
      csr_write(REG_SLACK, 1);
      csr_write(REG_MAXNEW, 0);
      random_phase(300);
      csr_write(REG_CLUSTER, 65536);
      csr_write(REG_SLACK, 65536);
      csr_write(REG_MAXNEW, 256);
      random_phase(300);
      csr_write(REG_CLUSTER, 32'hFFFF_FFFF);
      csr_write(REG_SLACK, 32'hFFFF_FFFF);
      csr_write(REG_MAXNEW, 1);
      random_phase(300);
      csr_write(REG_CLUSTER, 4096);
      csr_write(REG_SLACK, 64);
      csr_write(REG_MAXNEW, 511);
      random_phase(330);

      if (errors == 0)
         $display("chunk_pool_allocator: match");
      else
         $display("chunk_pool_allocator: mismatch");
      $finish;
   end
endmodule
